/* rtl/tlmf16_pkg.sv */
// ----------------------------------------------------------------------------
// tlmf16_pkg
// Shared types, header constants and checksum fold for the telemetry framer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlmf16_pkg;

	localparam logic [7:0] HDR_SYNC0      = 8'hAB;
	localparam logic [7:0] HDR_SYNC1      = 8'h55;
	localparam int         HDR_LEN        = 4;
	localparam int         FRAME_OVERHEAD = 6;
	localparam logic [7:0] SEED           = 8'hFF;

	// Payload byte held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} item_t;

	// Single fold of a 16-bit running sum: high byte added to low byte, modulo 256.
	function automatic logic [7:0] fold16(input logic [15:0] s);
		fold16 = s[7:0] + s[15:8];
	endfunction

endpackage

`default_nettype wire

/* rtl/tlmf16_in_stage.sv */
// ----------------------------------------------------------------------------
// tlmf16_in_stage
// Input register for payload bytes; frees itself when the sequencer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf16_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        payload_byte,
	input  wire logic              take,
	output tlmf16_pkg::item_t      item
);
	import tlmf16_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign in_ready   = !valid_s1 || take;
	assign item.valid = valid_s1;
	assign item.data  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= payload_byte;
		end
	end

endmodule

`default_nettype wire

/* rtl/tlmf16_sequencer.sv */
// ----------------------------------------------------------------------------
// tlmf16_sequencer
// Frame sequencer: emits header, payload and checksum bytes into the output
// register while updating the two running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf16_sequencer #(
	parameter int PAYLOAD_BYTES = 96
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tlmf16_pkg::item_t item,
	output logic                   take,
	input  wire logic [7:0]        message_id,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             frame_byte,
	output logic                   end_of_frame
);
	import tlmf16_pkg::*;

	localparam int POS_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int WGT_W = $clog2(PAYLOAD_BYTES + HDR_LEN + 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);
	localparam logic [7:0]  LEN_BYTE = 8'(PAYLOAD_BYTES + FRAME_OVERHEAD);
	localparam logic [15:0] SEED_A   = 16'(SEED);
	localparam logic [15:0] SEED_B   = 16'((PAYLOAD_BYTES + HDR_LEN + 1) * 255);
	localparam logic [WGT_W-1:0] DATA_WGT0 = WGT_W'(HDR_LEN + 1);

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_DATA, PH_CKA, PH_CKB
	} phase_t;

	phase_t               phase_q, phase_nxt;
	logic [POS_W-1:0]     pos_q;
	logic [15:0]          a_q, b_q;
	logic                 out_valid_q, eof_q;
	logic [7:0]           byte_q;

	logic                 out_free, need_item, absorb, emit, emit_eof, pos_last;
	logic [7:0]           emit_byte;
	logic [WGT_W-1:0]     weight;
	logic [WGT_W+7:0]     prod;
	logic [15:0]          a_base, b_base, a_nxt, b_nxt;

	assign out_free = !out_valid_q || out_ready;
	assign pos_last = (pos_q == POS_LAST);

	always_comb begin
		emit_byte = 8'h00;
		weight    = '0;
		need_item = 1'b1;
		absorb    = 1'b1;
		emit_eof  = 1'b0;
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_HDR0: begin
				emit_byte = HDR_SYNC0;
				weight    = WGT_W'(1);
				phase_nxt = PH_HDR1;
			end
			PH_HDR1: begin
				emit_byte = HDR_SYNC1;
				weight    = WGT_W'(2);
				phase_nxt = PH_HDR2;
			end
			PH_HDR2: begin
				emit_byte = message_id;
				weight    = WGT_W'(3);
				phase_nxt = PH_HDR3;
			end
			PH_HDR3: begin
				emit_byte = LEN_BYTE;
				weight    = WGT_W'(4);
				phase_nxt = PH_DATA;
			end
			PH_DATA: begin
				emit_byte = item.data;
				weight    = WGT_W'(pos_q) + DATA_WGT0;
				phase_nxt = pos_last ? PH_CKA : PH_DATA;
			end
			PH_CKA: begin
				emit_byte = fold16(a_q);
				need_item = 1'b0;
				absorb    = 1'b0;
				phase_nxt = PH_CKB;
			end
			PH_CKB: begin
				emit_byte = fold16(b_q);
				need_item = 1'b0;
				absorb    = 1'b0;
				emit_eof  = 1'b1;
				phase_nxt = PH_HDR0;
			end
			default: begin
				need_item = 1'b1;
				absorb    = 1'b0;
				phase_nxt = PH_HDR0;
			end
		endcase
	end

	assign emit   = out_free && (!need_item || item.valid);
	assign take   = emit && (phase_q == PH_DATA);
	assign prod   = emit_byte * weight;
	assign a_base = (phase_q == PH_HDR0) ? SEED_A : a_q;
	assign b_base = (phase_q == PH_HDR0) ? SEED_B : b_q;
	assign a_nxt  = a_base + 16'(emit_byte);
	assign b_nxt  = b_base + 16'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				pos_q <= pos_last ? '0 : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			eof_q  <= emit_eof;
		end
		if (emit && absorb) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = byte_q;
	assign end_of_frame = eof_q;

endmodule

`default_nettype wire

/* rtl/telemetry_framer_fletcher16_unit.sv */
// ----------------------------------------------------------------------------
// telemetry_framer_fletcher16_unit
// Telemetry framer with Fletcher-16 style checksum.
// ----------------------------------------------------------------------------
// Takes PAYLOAD_BYTES payload bytes per frame and sends PAYLOAD_BYTES+6 frame
// bytes: 0xAB, 0x55, message_id, length, payload, checksum A, checksum B
// (end_of_frame marks B). The output register sends one byte per cycle when
// out_ready does not stall it; payload bytes flow at one per cycle under the
// same condition. Input is held off while the four header bytes are sent, and
// no byte is taken from the input register while the two checksum bytes are
// sent. A payload byte passes through the input register and then the output
// register on its way to frame_byte; the first one of a frame waits behind
// the four header bytes. message_id is read when the header is sent, i.e.
// after the first payload byte of a frame is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_framer_fletcher16_unit #(
	parameter int PAYLOAD_BYTES = 96
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] payload_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      frame_byte,
	output logic            end_of_frame
);
	import tlmf16_pkg::*;

	logic [7:0] message_id_q;
	item_t      item;
	logic       take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_id_q <= 8'h08;
		end else if (cfg_we) begin
			message_id_q <= cfg_wdata;
		end
	end

	tlmf16_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.payload_byte(payload_byte),
		.take        (take),
		.item        (item)
	);

	tlmf16_sequencer #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.take        (take),
		.message_id  (message_id_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_byte  (frame_byte),
		.end_of_frame(end_of_frame)
	);

endmodule

`default_nettype wire

/* rtl/tlmf16_checker.sv */
// ----------------------------------------------------------------------------
// tlmf16_checker
// Port-level checks on the framer output: frame structure and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tlmf16_checker #(
	parameter int PAYLOAD_BYTES = 96
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] frame_byte,
	input wire logic       end_of_frame
);
	import tlmf16_pkg::*;

	localparam int FRAME_LEN = PAYLOAD_BYTES + FRAME_OVERHEAD;
	localparam int CNT_W     = $clog2(FRAME_LEN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);
	localparam logic [CNT_W-1:0] CNT_SYNC1 = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_LEN = CNT_W'(3);
	localparam logic [7:0] LEN_BYTE = 8'(FRAME_LEN);

	logic             out_acc;
	logic [CNT_W-1:0] cnt_q;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (out_acc) begin
			cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(end_of_frame))
		else $error("output request changed while stalled");

	a_eof_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (end_of_frame == (cnt_q == CNT_LAST)))
		else $error("end_of_frame not on last frame byte");

	a_sync0: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (cnt_q == '0) |-> (frame_byte == HDR_SYNC0))
		else $error("frame does not start with first sync byte");

	a_sync1: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (cnt_q == CNT_SYNC1) |-> (frame_byte == HDR_SYNC1))
		else $error("second sync byte wrong");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && (cnt_q == CNT_LEN) |-> (frame_byte == LEN_BYTE))
		else $error("length byte wrong");

endmodule

bind telemetry_framer_fletcher16_unit tlmf16_checker #(
	.PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_tlmf16_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.frame_byte  (frame_byte),
	.end_of_frame(end_of_frame)
);

`default_nettype wire
